### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit converter.
// Synthesis builds see empty bodies; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/core/i2rd_pkg.sv
// Types and constants for the radix digit converter.
// No dependencies; imported by every module of the block.
package i2rd_pkg;

	localparam int RADIX_W    = 6;
	localparam int DIGIT_W    = 5;
	localparam int MAX_DIGITS = 32;
	localparam int SYM_SLOTS  = 32;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef logic [SYM_SLOTS-1:0][7:0] sym_tab_t;
	typedef logic [DIGIT_W-1:0] digit_t;

endpackage

### rtl/core/i2rd_div_step.sv
// Shared divide step: eight restoring long-division steps per call.
// Depends on i2rd_pkg for the digit and radix widths.
module i2rd_div_step
	import i2rd_pkg::*;
(
	input  logic [DIGIT_W-1:0] rem_in,
	input  logic [7:0]         bits_in,
	input  logic [RADIX_W-1:0] divisor,
	output logic [DIGIT_W-1:0] rem_out,
	output logic [7:0]         quo_out
);

	always_comb begin
		logic [DIGIT_W:0] r;
		r = {1'b0, rem_in};
		quo_out = '0;
		for (int k = 7; k >= 0; k--) begin
			r = {r[DIGIT_W-1:0], bits_in[k]};
			if (r >= divisor) begin
				r = r - divisor;
				quo_out[k] = 1'b1;
			end
		end
		rem_out = r[DIGIT_W-1:0];
	end

endmodule

### rtl/core/integer_to_radix_digits.sv
// Top level of the radix digit converter: configuration port, sequencer, output register.
// Depends on i2rd_pkg, i2rd_div_step and assert_macros.svh.
//
// Each item is a signed 32-bit number that comes out as text, one character per output
// item, a leading '-' for negatives and the final character flagged by last. The block
// takes one item at a time. It first checks the digit set, one symbol a cycle (an
// out-of-range radix is rejected in the accepting cycle). It then divides repeatedly by
// the radix through one shared eight-bit divide step, a byte of the magnitude per pass,
// and finally emits one character a cycle while the consumer is ready. An invalid digit
// set produces no output at all.
`include "assert_macros.svh"

module integer_to_radix_digits
	import i2rd_pkg::*;
#(
	parameter int MAX_RADIX = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         character,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	localparam int LIMIT_INT = (MAX_RADIX < SYM_SLOTS) ? MAX_RADIX : SYM_SLOTS;
	localparam logic [RADIX_W-1:0] RADIX_LIMIT = RADIX_W'(LIMIT_INT);

	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_SYM0  = 3'd1;
	localparam logic [2:0] REG_SYM1  = 3'd2;
	localparam logic [2:0] REG_SYM2  = 3'd3;
	localparam logic [2:0] REG_SYM3  = 3'd4;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [RADIX_W-1:0] radix_q;
	logic [3:0][63:0]   sym_reg_q;
	sym_tab_t           sym_tab;

	logic [2:0]           state_q;
	logic                 neg_q;
	logic [31:0]          mag_q;
	logic [23:0]          quot_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [1:0]           byte_cnt_q;
	logic [5:0]           nd_q;
	logic [4:0]           chk_idx_q;
	digit_t               digit_q [MAX_DIGITS];
	logic                 out_valid_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic [2:0]         reg_idx;
	logic               wr_en;
	logic [31:0]        raw;
	logic [31:0]        raw_mag;
	logic               count_ok;
	logic [7:0]         chk_sym;
	logic               chk_dup;
	logic               chk_bad;
	logic [DIGIT_W-1:0] rem_next;
	logic [7:0]         quo_bits;
	logic [31:0]        quot_full;
	logic               out_free;
	logic               out_load;
	logic [4:0]         emit_idx;

	assign sym_tab = sym_tab_t'(sym_reg_q);
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= RADIX_W'(10);
			sym_reg_q[0] <= 64'h3736_3534_3332_3130;
			sym_reg_q[1] <= 64'h0000_0000_0000_3939;
			sym_reg_q[2] <= 64'h0;
			sym_reg_q[3] <= 64'h0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RADIX: radix_q      <= pwdata[RADIX_W-1:0];
				REG_SYM0:  sym_reg_q[0] <= pwdata;
				REG_SYM1:  sym_reg_q[1] <= pwdata;
				REG_SYM2:  sym_reg_q[2] <= pwdata;
				REG_SYM3:  sym_reg_q[3] <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIX: prdata = {{(64-RADIX_W){1'b0}}, radix_q};
			REG_SYM0:  prdata = sym_reg_q[0];
			REG_SYM1:  prdata = sym_reg_q[1];
			REG_SYM2:  prdata = sym_reg_q[2];
			REG_SYM3:  prdata = sym_reg_q[3];
			default:   prdata = 64'h0;
		endcase
	end

	assign raw      = number;
	assign raw_mag  = raw[31] ? (~raw + 32'd1) : raw;
	assign count_ok = (radix_q >= RADIX_W'(2)) && (radix_q <= RADIX_LIMIT);

	assign chk_sym = sym_tab[chk_idx_q];

	always_comb begin
		chk_dup = 1'b0;
		for (int j = 0; j < SYM_SLOTS; j++) begin
			if ((5'(j) < chk_idx_q) && (sym_tab[j] == chk_sym)) begin
				chk_dup = 1'b1;
			end
		end
	end

	assign chk_bad = chk_dup || (chk_sym == CHAR_NUL) || (chk_sym == CHAR_PLUS)
		|| (chk_sym == CHAR_MINUS);

	i2rd_div_step u_div_step (
		.rem_in  (rem_q),
		.bits_in (mag_q[31:24]),
		.divisor (radix_q),
		.rem_out (rem_next),
		.quo_out (quo_bits)
	);

	assign quot_full = {quot_q, quo_bits};
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT));
	assign emit_idx  = 5'(nd_q - 6'd1);
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			nd_q        <= '0;
			chk_idx_q   <= '0;
			byte_cnt_q  <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q      <= raw[31];
						mag_q      <= raw_mag;
						nd_q       <= '0;
						chk_idx_q  <= '0;
						byte_cnt_q <= '0;
						rem_q      <= '0;
						state_q    <= count_ok ? ST_CHECK : ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (chk_bad) begin
						state_q <= ST_IDLE;
					end else if ({1'b0, chk_idx_q} == radix_q - RADIX_W'(1)) begin
						state_q <= ST_DIV;
					end else begin
						chk_idx_q <= chk_idx_q + 5'd1;
					end
				end
				ST_DIV: begin
					byte_cnt_q <= byte_cnt_q + 2'd1;
					if (byte_cnt_q == 2'd3) begin
						digit_q[nd_q[4:0]] <= rem_next;
						nd_q               <= nd_q + 6'd1;
						mag_q              <= quot_full;
						rem_q              <= '0;
						if (quot_full == 32'd0) begin
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end else begin
						mag_q  <= {mag_q[23:0], 8'h00};
						quot_q <= {quot_q[15:0], quo_bits};
						rem_q  <= rem_next;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						char_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						char_q      <= sym_tab[digit_q[emit_idx]];
						last_q      <= (nd_q == 6'd1);
						nd_q        <= nd_q - 6'd1;
						if (nd_q == 6'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	`ASSERT_NEVER(a_digit_count_bound, clk, arst_n, nd_q > 6'(MAX_DIGITS))
	`ASSERT_PROP(a_rem_below_radix, clk, arst_n,
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < radix_q))
	`ASSERT_PROP(a_accept_next, clk, arst_n,
		(in_valid && in_ready) |=> (state_q == ST_CHECK || state_q == ST_IDLE))
	`ASSERT_NEVER(a_emit_has_digit, clk, arst_n, (state_q == ST_EMIT) && (nd_q == 6'd0))

endmodule

### tb/tb_integer_to_radix_digits.sv
`timescale 1ns / 100ps
// Testbench for integer_to_radix_digits: renders signed numbers under many digit sets and
// checks every character against a predictor held in a small scoreboard class.
// Depends on i2rd_pkg and the RTL of the block; needs nothing else.
module tb_integer_to_radix_digits
	import i2rd_pkg::*;
;

	localparam int TB_MAX_RADIX  = 32;
	localparam int RANDOM_ITEMS  = 355;
	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT   = 4000;

	typedef enum int {
		REG_RADIX,
		REG_SYM_0_7,
		REG_SYM_8_15,
		REG_SYM_16_23,
		REG_SYM_24_31,
		REG_SPARE
	} reg_index_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_char_t;

	class digit_scoreboard;
		logic [5:0]  radix;
		sym_tab_t    syms;
		text_char_t  text_q[$];
		int unsigned errors;
		int unsigned chars_checked;
		int unsigned numbers_rendered;
		int unsigned numbers_dropped;

		function new();
			radix = 6'd10;
			syms = '0;
			set_word(0, 64'd3978425819141910832);
			set_word(1, 64'd14649);
		endfunction

		function void set_word(int k, logic [63:0] data);
			logic [255:0] flat;
			flat = syms;
			flat[64 * k +: 64] = data;
			syms = flat;
		endfunction

		function void note_write(reg_index_e idx, logic [63:0] data);
			if (idx == REG_RADIX) begin
				radix = data[5:0];
			end else if (idx <= REG_SYM_24_31) begin
				set_word(idx - REG_SYM_0_7, data);
			end
		endfunction

		function bit digit_set_ok();
			bit seen [0:255] = '{default: 1'b0};
			if (radix < 2 || radix > TB_MAX_RADIX || radix > SYM_SLOTS)
				return 1'b0;
			for (int i = 0; i < radix; i++) begin
				if (syms[i] == CHAR_NUL || syms[i] == CHAR_PLUS || syms[i] == CHAR_MINUS)
					return 1'b0;
				if (seen[syms[i]])
					return 1'b0;
				seen[syms[i]] = 1'b1;
			end
			return 1'b1;
		endfunction

		// Digits are collected least significant first and stored the other way round.
		function void note_number(logic signed [31:0] value);
			logic [31:0] mag;
			logic [31:0] base;
			int          digs[$];
			if (!digit_set_ok()) begin
				numbers_dropped++;
				return;
			end
			numbers_rendered++;
			base = 32'(radix);
			mag = value[31] ? 32'd0 - value : value;
			do begin
				digs.push_front(int'(mag % base));
				mag = mag / base;
			end while (mag != 0);
			if (value[31])
				text_q.push_back('{ch: CHAR_MINUS, fin: 1'b0});
			foreach (digs[i])
				text_q.push_back('{ch: syms[digs[i]], fin: i == digs.size() - 1});
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_char(logic [7:0] ch, logic fin);
			text_char_t want;
			chars_checked++;
			if (text_q.size() == 0) begin
				report($sformatf("character %h with nothing expected", ch));
			end else begin
				want = text_q.pop_front();
				if (ch !== want.ch)
					report($sformatf("character %h, expected %h", ch, want.ch));
				if (fin !== want.fin)
					report($sformatf("last %b, expected %b", fin, want.fin));
			end
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic signed [31:0] number    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         character;
	logic               last;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [5:0]         paddr     = '0;
	logic [63:0]        pwdata    = '0;
	logic [63:0]        prdata;
	logic               pready;

	bit              steady   = 1'b0;
	int              settings = 0;
	digit_scoreboard book     = new();

	integer_to_radix_digits u_top (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_char(character, last);
		out_ready <= steady || $urandom_range(0, 99) >= 28;
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles without a handshake", STALL_LIMIT);
		$display("tb_integer_to_radix_digits failed");
		$finish;
	end

	task automatic send_number(input logic signed [31:0] value);
		while (!steady && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		number <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		book.note_number(value);
	endtask

	// Registers change only once the block has drained and had time to finish any item
	// that was dropped on an invalid digit set.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.text_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_index_e idx, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(8 * idx);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		book.note_write(idx, data);
	endtask

	task automatic load_set(input int count, input sym_tab_t tab);
		logic [255:0] flat;
		logic [63:0]  radix_word;
		flat = tab;
		radix_word = {$urandom, $urandom};
		radix_word[5:0] = count[5:0];
		wait_idle();
		write_reg(REG_RADIX, radix_word);
		for (int k = 0; k < 4; k++)
			write_reg(reg_index_e'(REG_SYM_0_7 + k), flat[64 * k +: 64]);
		settings++;
	endtask

	function automatic sym_tab_t decimal_set();
		sym_tab_t tab;
		tab = '0;
		for (int i = 0; i < 10; i++)
			tab[i] = 8'h30 + 8'(i);
		return tab;
	endfunction

	// Thirty-two distinct symbols that include the byte extremes and the neighbours of the
	// sign characters.
	function automatic sym_tab_t wide_set();
		sym_tab_t tab;
		for (int i = 0; i < SYM_SLOTS; i++)
			tab[i] = 8'(1 + 8 * i);
		tab[27] = 8'h80;
		tab[28] = CHAR_MINUS + 8'd1;
		tab[29] = CHAR_PLUS + 8'd1;
		tab[30] = 8'hFF;
		return tab;
	endfunction

	function automatic sym_tab_t random_set(int count);
		sym_tab_t   tab;
		bit         used [0:255] = '{default: 1'b0};
		int         n;
		logic [7:0] b;
		n = 0;
		for (int i = 0; i < SYM_SLOTS; i++)
			tab[i] = 8'($urandom);
		while (n < count) begin
			b = 8'($urandom_range(1, 255));
			if (b != CHAR_PLUS && b != CHAR_MINUS && !used[b]) begin
				used[b] = 1'b1;
				tab[n] = b;
				n++;
			end
		end
		return tab;
	endfunction

	function automatic logic signed [31:0] random_number(int count);
		logic signed [31:0] value;
		case ($urandom_range(0, 4))
			0, 1: value = $urandom;
			2: value = $urandom >> $urandom_range(0, 31);
			3: value = $urandom_range(0, count * count + 1);
			default: value = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		endcase
		if (value != 32'sh8000_0000 && $urandom_range(0, 2) == 0)
			value = -value;
		return value;
	endfunction

	initial begin
		sym_tab_t tab;
		int       count;
		int       dup;
		int       phase;
		int       goal;
		bit       broken;

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset symbols repeat the digit nine, so nothing comes out.
		send_number(32'sd7);
		send_number(-32'sd7);

		tab = decimal_set();
		load_set(10, tab);
		send_number(0);
		send_number(1);
		send_number(-1);
		send_number(9);
		send_number(10);
		send_number(-10);
		send_number(32'sh7FFF_FFFF);
		send_number(32'sh8000_0000);
		send_number(32'sd1000000007);

		load_set(2, tab);
		send_number(32'sh8000_0000);
		send_number(32'sh7FFF_FFFF);
		send_number(-1);
		send_number(0);
		send_number(5);

		tab = wide_set();
		load_set(32, tab);
		send_number(32'sh8000_0000);
		send_number(32'sh7FFF_FFFF);
		send_number(31);
		send_number(32);
		send_number(-33);

		load_set(33, tab);
		send_number(5);
		load_set(63, tab);
		send_number(-5);

		tab = decimal_set();
		load_set(0, tab);
		send_number(3);
		load_set(1, tab);
		send_number(3);
		tab[7] = tab[3];
		load_set(10, tab);
		send_number(12);
		tab = decimal_set();
		tab[9] = CHAR_PLUS;
		load_set(10, tab);
		send_number(12);
		tab = decimal_set();
		tab[0] = CHAR_MINUS;
		load_set(10, tab);
		send_number(12);
		tab = decimal_set();
		tab[5] = CHAR_NUL;
		load_set(10, tab);
		send_number(12);

		// Slots above the radix may hold anything, and the spare address must be ignored.
		tab = decimal_set();
		tab[10] = CHAR_PLUS;
		tab[11] = CHAR_NUL;
		load_set(10, tab);
		write_reg(REG_SPARE, {$urandom, $urandom});
		send_number(-32'sd123456789);
		send_number(42);

		goal = book.numbers_rendered + RANDOM_ITEMS;
		phase = 0;
		while (book.numbers_rendered < goal) begin
			count = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4)
				: $urandom_range(2, TB_MAX_RADIX);
			tab = random_set(count);
			broken = $urandom_range(0, 5) == 0;
			if (broken) begin
				case ($urandom_range(0, 4))
					0: count = $urandom_range(0, 1);
					1: count = $urandom_range(TB_MAX_RADIX + 1, 63);
					2: tab[$urandom_range(0, count - 1)] = CHAR_PLUS;
					3: tab[$urandom_range(0, count - 1)] =
						$urandom_range(0, 1) ? CHAR_MINUS : CHAR_NUL;
					default: begin
						dup = $urandom_range(1, count - 1);
						tab[dup] = tab[$urandom_range(0, dup - 1)];
					end
				endcase
			end
			load_set(count, tab);
			steady <= phase == 3;
			repeat (broken ? 4 : $urandom_range(20, 50))
				send_number(random_number(count));
			phase++;
		end
		steady <= 1'b0;
		wait_idle();

		$display("Rendered %0d numbers as %0d checked characters over %0d register settings,",
			book.numbers_rendered, book.chars_checked, settings);
		$display("and %0d numbers met an invalid digit set and were dropped.",
			book.numbers_dropped);
		if (book.errors == 0) begin
			$display("tb_integer_to_radix_digits passed");
		end else begin
			$display("%0d mismatches in total", book.errors);
			$display("tb_integer_to_radix_digits failed");
		end
		$finish;
	end

endmodule
